// ===== hdl/ptq_pkg.sv =====
// ptq_pkg: shared types and constants of the priority task queue.
// Used by ptq_cell and priority_task_queue; depends on nothing.
`timescale 1ns / 1ps

package ptq_pkg;

    // Number of cells in the chain (2 .. 256).
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PENDING_W   = 5;
    localparam int ID_W        = 16;
    localparam int PRIO_W      = 8;
    localparam int KIND_W      = 2;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [KIND_W-1:0] kind;
    } t_entry;

    // Command broadcast to every cell for one word.
    typedef struct packed {
        logic   ins;
        logic   disp;
        t_entry entry;
    } t_cell_cmd;

    // What a cell hands to its neighbors.
    typedef struct packed {
        logic   valid;
        logic   beats;   // new entry goes ahead of this cell's entry
        t_entry entry;
    } t_cell_link;

    typedef enum logic [1:0] {
        OUT_QUEUED     = 2'd0,
        OUT_DROPPED    = 2'd1,
        OUT_DISPATCHED = 2'd2,
        OUT_IDLE       = 2'd3
    } t_outcome;

endpackage

// ===== hdl/ptq_cell.sv =====
// ptq_cell: one slot of the sorted cell chain.
// Depends on ptq_pkg for the entry, command and link types.
`timescale 1ns / 1ps

module ptq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptq_pkg::t_cell_cmd i_cmd,
    input  ptq_pkg::t_cell_link i_left,
    input  ptq_pkg::t_cell_link i_right,
    output ptq_pkg::t_cell_link o_link
);
    import ptq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   beats;

    // Strictly greater keeps arrival order among equal priorities.
    assign beats = !r_valid || (i_cmd.entry.prio > r_entry.prio);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_left.beats) begin
                // shift right: take the neighbor's entry
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else if (beats) begin
                n_valid = 1'b1;
                n_entry = i_cmd.entry;
            end
        end else if (i_cmd.disp) begin
            // shift left toward the head
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.valid = r_valid;
    assign o_link.beats = beats;
    assign o_link.entry = r_entry;

endmodule

// ===== hdl/priority_task_queue.sv =====
// priority_task_queue: bounded priority queue with first-come order among equal priorities.
// Depends on ptq_pkg and ptq_cell (one cell per queue slot).
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------------------
//  in      | into      | i_in_valid / o_in_stall   | mode, task id, priority, kind
//  out     | out of    | o_out_valid / i_out_stall | outcome, id, priority, kind, pending
//
//  Each accepted word updates the whole chain together; its result word sits in the
//  output register from the next cycle on. A new word is taken whenever that register is
//  empty or is being taken in the same cycle, so one word per cycle flows when the output
//  side does not stall. Reset (synchronous, active low) empties every cell and the output
//  register at once. While the output register holds a word and the output side stalls,
//  o_in_stall is high.
//
//  The chain is kept sorted: cell 0 holds the highest priority, the earliest arrival first
//  among equals. An insert drops the new word into the first cell whose entry it beats and
//  shifts the rest right; a dispatch takes cell 0 and shifts everything left.

module priority_task_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_mode,
    input  logic [ptq_pkg::ID_W-1:0]  i_task_id,
    input  logic [ptq_pkg::PRIO_W-1:0] i_task_priority,
    input  logic [ptq_pkg::KIND_W-1:0] i_task_kind,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_outcome,
    output logic [ptq_pkg::ID_W-1:0]  o_out_id,
    output logic [ptq_pkg::PRIO_W-1:0] o_out_priority,
    output logic [ptq_pkg::KIND_W-1:0] o_out_kind,
    output logic [ptq_pkg::PENDING_W-1:0] o_pending
);
    import ptq_pkg::*;

    localparam int WIDE_W = (COUNT_W > PENDING_W) ? COUNT_W : PENDING_W;

    // Control state
    logic     r_out_valid;
    logic     n_out_valid;
    t_count   r_count;
    t_count   n_count;

    // Output word
    t_outcome r_outcome;
    t_outcome n_outcome;
    t_entry   r_res;
    t_entry   n_res;
    logic [PENDING_W-1:0] r_pending;
    logic [PENDING_W-1:0] n_pending;

    logic      in_accept;
    logic      out_take;
    logic      full;
    logic      empty;
    t_cell_cmd cmd;
    t_entry    new_entry;
    logic [WIDE_W-1:0] count_ext;

    t_cell_link links [QUEUE_DEPTH];
    t_cell_link edge_left;
    t_cell_link edge_right;
    logic [QUEUE_DEPTH-1:0] valid_vec;

    // Handshake: hold the input while the result register is full and stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    assign full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    assign new_entry.id   = i_task_id;
    assign new_entry.prio = i_task_priority;
    assign new_entry.kind = i_task_kind;

    // Broadcast the word to every cell; drop inserts when full, idle dispatches when empty.
    assign cmd.ins   = in_accept && !i_mode && !full;
    assign cmd.disp  = in_accept && i_mode && !empty;
    assign cmd.entry = new_entry;

    // Chain ends: nothing beats beyond the head, nothing valid past the tail.
    assign edge_left.valid  = 1'b0;
    assign edge_left.beats  = 1'b0;
    assign edge_left.entry  = '0;
    assign edge_right.valid = 1'b0;
    assign edge_right.beats = 1'b0;
    assign edge_right.entry = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_link left_in;
        t_cell_link right_in;

        if (g == 0) begin : g_head
            assign left_in = edge_left;
        end else begin : g_mid_l
            assign left_in = links[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_in = edge_right;
        end else begin : g_mid_r
            assign right_in = links[g+1];
        end

        ptq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  (left_in),
            .i_right (right_in),
            .o_link  (links[g])
        );

        assign valid_vec[g] = links[g].valid;
    end

    // Next count and result word.
    always_comb begin
        n_count   = r_count;
        n_outcome = r_outcome;
        n_res     = r_res;
        if (in_accept) begin
            n_res = '0;
            if (!i_mode) begin
                if (full) begin
                    n_outcome = OUT_DROPPED;
                end else begin
                    n_outcome = OUT_QUEUED;
                    n_count   = r_count + COUNT_W'(1);
                end
            end else begin
                if (empty) begin
                    n_outcome = OUT_IDLE;
                end else begin
                    n_outcome = OUT_DISPATCHED;
                    n_res     = links[0].entry;
                    n_count   = r_count - COUNT_W'(1);
                end
            end
        end
    end

    // Pending reports the count masked to its field width.
    assign count_ext = WIDE_W'(n_count);
    assign n_pending = in_accept ? count_ext[PENDING_W-1:0] : r_pending;

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outcome <= n_outcome;
        r_res     <= n_res;
        r_pending <= n_pending;
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_out_id       = r_res.id;
    assign o_out_priority = r_res.prio;
    assign o_out_kind     = r_res.kind;
    assign o_pending      = r_pending;

    // Count never passes the number of cells.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Occupied cells match the count.
    a_count_cells : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    // Head is never outranked by its neighbor.
    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        links[1].valid |-> (links[0].valid && links[0].entry.prio >= links[1].entry.prio))
        else $error("chain not sorted at head");

    // An accepted word always leaves a result in the output register.
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted word produced no result");

endmodule
